// ----- sv/qafc_pkg.sv -----
// ----------------------------------------------------------------------------
// qafc_pkg
// Types and constants shared by the Q-algorithm frame controller.
// ----------------------------------------------------------------------------
`default_nettype none

package qafc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned EXP_W      = 4;
  localparam int unsigned SLOT_W     = 15;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned QLVL_W     = 12;
  localparam int unsigned STEP_W     = 8;

  localparam logic [EXP_W-1:0]  INITIAL_Q_RST = 4'd6;
  localparam logic [STEP_W-1:0] Q_STEP_RST    = 8'd26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_Q = 1'b0,
    CFG_Q_STEP    = 1'b1
  } qafc_cfg_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_SLOT  = 1'b1
  } qafc_op_e;

  typedef enum logic [1:0] {
    OUTC_IDLE      = 2'd0,
    OUTC_SUCCESS   = 2'd1,
    OUTC_COLLISION = 2'd2
  } qafc_outc_e;

  typedef enum logic [1:0] {
    CMD_NEXT_SLOT  = 2'd0,
    CMD_NEW_FRAME  = 2'd1,
    CMD_ROUND_DONE = 2'd2,
    CMD_NO_ROUND   = 2'd3
  } qafc_cmd_e;

  typedef struct packed {
    logic [EXP_W-1:0]  exponent;
    logic [SLOT_W-1:0] slot;
    logic              coll;
    logic              active;
  } qafc_ctrl_t;

  typedef struct packed {
    logic [EXP_W-1:0]  initial_q;
    logic [STEP_W-1:0] q_step;
  } qafc_cfg_t;

endpackage

`default_nettype wire

// ----- sv/qafc_req_if.sv -----
// ----------------------------------------------------------------------------
// qafc_req_if
// Request channel: operation and slot outcome with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface qafc_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] slot_outcome;

  modport source (output valid, operation, slot_outcome, input ready);
  modport sink (input valid, operation, slot_outcome, output ready);
endinterface

`default_nettype wire

// ----- sv/qafc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// qafc_rsp_if
// Result channel: frame command and controller state with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface qafc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  frame_exponent;
  logic [15:0] frame_slots;
  logic [14:0] slot_index;
  logic [11:0] q_level;

  modport source (
    output valid, command, frame_exponent, frame_slots, slot_index, q_level,
    input ready
  );
  modport sink (
    input valid, command, frame_exponent, frame_slots, slot_index, q_level,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/qafc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// qafc_cfg_regs
// Configuration registers: initial Q and Q adjustment step.
// ----------------------------------------------------------------------------
`default_nettype none

module qafc_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [qafc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [qafc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output qafc_pkg::qafc_cfg_t                     cfg_o
);
  import qafc_pkg::*;

  qafc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_q <= INITIAL_Q_RST;
      cfg_q.q_step    <= Q_STEP_RST;
    end else if (cfg_we_i) begin
      case (qafc_cfg_e'(cfg_idx_i))
        CFG_INITIAL_Q: cfg_q.initial_q <= cfg_wdata_i[EXP_W-1:0];
        CFG_Q_STEP:    cfg_q.q_step    <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/qafc_step.sv -----
// ----------------------------------------------------------------------------
// qafc_step
// Next-state logic for one request: Q adjust, clamp, rounding, slot advance.
// ----------------------------------------------------------------------------
`default_nettype none

module qafc_step #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned Q_MAX     = 15,
  parameter int unsigned QW        = 12
) (
  input  wire logic                    operation_i,
  input  wire logic [1:0]              slot_outcome_i,
  input  wire qafc_pkg::qafc_cfg_t     cfg_i,
  input  wire logic [QW-1:0]           q_i,
  input  wire qafc_pkg::qafc_ctrl_t    ctrl_i,
  output logic [QW-1:0]                q_o,
  output qafc_pkg::qafc_ctrl_t         ctrl_o,
  output qafc_pkg::qafc_cmd_e          cmd_o
);
  import qafc_pkg::*;

  localparam logic [EXP_W-1:0] QMAX_E = EXP_W'(Q_MAX);
  localparam logic [QW:0]      Q_CAP  = (QW+1)'(Q_MAX) << FRAC_BITS;
  localparam logic [QW:0]      Q_HALF = (QW+1)'(1) << (FRAC_BITS - 1);

  logic [EXP_W-1:0]  iq;
  logic              coll;
  logic [SLOT_W-1:0] last;
  logic              at_last;
  logic [QW:0]       step_x;
  logic [QW:0]       q_x;
  logic [QW:0]       q_sum;
  logic [QW:0]       q_adj;
  logic [QW:0]       q_rnd;
  logic [EXP_W-1:0]  e;

  assign iq      = (cfg_i.initial_q > QMAX_E) ? QMAX_E : cfg_i.initial_q;
  assign coll    = ctrl_i.coll || (slot_outcome_i == OUTC_COLLISION);
  assign last    = SLOT_W'((SIZE_W'(1) << ctrl_i.exponent) - SIZE_W'(1));
  assign at_last = (ctrl_i.slot >= last);
  assign step_x  = (QW+1)'(cfg_i.q_step);
  assign q_x     = {1'b0, q_i};
  assign q_sum   = q_x + step_x;

  always_comb begin
    case (slot_outcome_i)
      OUTC_IDLE:      q_adj = (q_x > step_x) ? (q_x - step_x) : '0;
      OUTC_COLLISION: q_adj = (q_sum > Q_CAP) ? Q_CAP : q_sum;
      default:        q_adj = q_x;
    endcase
  end

  assign q_rnd = (q_adj + Q_HALF) >> FRAC_BITS;
  assign e     = (q_rnd > (QW+1)'(Q_MAX)) ? QMAX_E : q_rnd[EXP_W-1:0];

  always_comb begin
    q_o    = q_i;
    ctrl_o = ctrl_i;
    cmd_o  = CMD_NO_ROUND;
    if (operation_i == OP_START) begin
      q_o             = QW'(iq) << FRAC_BITS;
      ctrl_o.exponent = iq;
      ctrl_o.slot     = '0;
      ctrl_o.coll     = 1'b0;
      ctrl_o.active   = 1'b1;
      cmd_o           = CMD_NEW_FRAME;
    end else if (ctrl_i.active) begin
      ctrl_o.coll = coll;
      if (at_last && !coll) begin
        ctrl_o.active = 1'b0;
        ctrl_o.slot   = '0;
        cmd_o         = CMD_ROUND_DONE;
      end else begin
        q_o = q_adj[QW-1:0];
        if ((e != ctrl_i.exponent) || at_last) begin
          ctrl_o.exponent = e;
          ctrl_o.slot     = '0;
          ctrl_o.coll     = 1'b0;
          cmd_o           = CMD_NEW_FRAME;
        end else begin
          ctrl_o.slot = ctrl_i.slot + SLOT_W'(1);
          cmd_o       = CMD_NEXT_SLOT;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/q_algorithm_frame_controller.sv -----
// ----------------------------------------------------------------------------
// q_algorithm_frame_controller
// Reader-side Q-algorithm: tracks Q, frame size and slot index per request.
// A result passes the input register, then the result register, before it
// is valid; the result register holds while rsp_o.ready is low.
// Throughput: one request per cycle unless rsp_o.ready stalls; next state is combinational.
// Reset: round inactive, Q, exponent and slot cleared; initial_q 6, q_step 26.
// ----------------------------------------------------------------------------
`default_nettype none

module q_algorithm_frame_controller #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned Q_MAX     = 15
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [qafc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [qafc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  qafc_req_if.sink                             req_i,
  qafc_rsp_if.source                           rsp_o
);
  import qafc_pkg::*;

  localparam int unsigned QW = EXP_W + FRAC_BITS;

  qafc_cfg_t  cfg;
  logic       in_vld_q;
  logic       op_q;
  logic [1:0] outc_q;
  logic       adv;

  logic [QW-1:0] q_q, q_d;
  qafc_ctrl_t    ctrl_q, ctrl_d;
  qafc_cmd_e     cmd_d;

  logic              out_vld_q;
  qafc_cmd_e         cmd_q;
  logic [EXP_W-1:0]  exp_q;
  logic [SIZE_W-1:0] size_q;
  logic [SLOT_W-1:0] slot_q;
  logic [QLVL_W-1:0] qlvl_q;

  qafc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      op_q   <= req_i.operation;
      outc_q <= req_i.slot_outcome;
    end
  end

  qafc_step #(
    .FRAC_BITS(FRAC_BITS),
    .Q_MAX    (Q_MAX),
    .QW       (QW)
  ) u_step (
    .operation_i   (op_q),
    .slot_outcome_i(outc_q),
    .cfg_i         (cfg),
    .q_i           (q_q),
    .ctrl_i        (ctrl_q),
    .q_o           (q_d),
    .ctrl_o        (ctrl_d),
    .cmd_o         (cmd_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q       <= '0;
      ctrl_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        q_q    <= q_d;
        ctrl_q <= ctrl_d;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q  <= cmd_d;
      exp_q  <= ctrl_d.exponent;
      size_q <= SIZE_W'(1) << ctrl_d.exponent;
      slot_q <= ctrl_d.slot;
      qlvl_q <= QLVL_W'(q_d);
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.command        = cmd_q;
  assign rsp_o.frame_exponent = exp_q;
  assign rsp_o.frame_slots    = size_q;
  assign rsp_o.slot_index     = slot_q;
  assign rsp_o.q_level        = qlvl_q;

endmodule

`default_nettype wire
